// ===== hdl/bam_pkg.sv =====
// shared types and constants for the brush alpha stamp pipeline
`timescale 1ns / 1ps

package bam_pkg;

    localparam int MAP_SIDE = 64;
    localparam int IDX_W = $clog2(MAP_SIDE);

    localparam int DIV_STEPS = 32;
    localparam int SQRT_STEPS = 16;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] MIN_FALLOFF = 17'd66;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERASE = 3'd5;

    typedef struct packed {
        logic [7:0] alpha;
        logic       in_brush;
        logic       flag;
    } t_side;

endpackage

// ===== hdl/bam_if.sv =====
// stream and configuration interfaces of the brush alpha stamp
`timescale 1ns / 1ps

interface bam_in_if;
    logic                        valid;
    logic                        ready;
    logic [bam_pkg::IDX_W-1:0]   texel_row;
    logic [bam_pkg::IDX_W-1:0]   texel_col;
    logic [7:0]                  current_alpha;

    modport source (output valid, texel_row, texel_col, current_alpha, input ready);
    modport sink (input valid, texel_row, texel_col, current_alpha, output ready);
endinterface

interface bam_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] new_alpha;
    logic       inside_brush;

    modport source (output valid, new_alpha, inside_brush, input ready);
    modport sink (input valid, new_alpha, inside_brush, output ready);
endinterface

interface bam_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bam_pkg::CFG_IDX_W-1:0]   index;
    logic [bam_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bam_div.sv =====
// pipelined restoring divider, one quotient bit per stage, numerator below divisor
`timescale 1ns / 1ps

module bam_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [31:0]           i_num,
    input  logic [31:0]           i_den,
    input  bam_pkg::t_side        i_side,
    output logic                  o_vld,
    output logic [31:0]           o_quo,
    output bam_pkg::t_side        o_side
);

    localparam int N = bam_pkg::DIV_STEPS;

    logic [N-1:0]   r_vld;
    logic [31:0]    r_rem [N];
    logic [31:0]    r_den [N];
    logic [31:0]    r_quo [N];
    bam_pkg::t_side r_side [N];

    logic [31:0]    n_rem [N];
    logic [31:0]    n_quo [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [31:0]    p_rem;
        logic [31:0]    p_den;
        logic [31:0]    p_quo;
        bam_pkg::t_side p_side;
        logic [32:0]    sh;
        logic           ge;

        if (k == 0) begin : g_first
            assign p_rem = i_num;
            assign p_den = i_den;
            assign p_quo = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_quo = r_quo[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            sh = {p_rem, 1'b0};
            ge = sh >= {1'b0, p_den};
            n_rem[k] = ge ? 32'(sh - {1'b0, p_den}) : sh[31:0];
            n_quo[k] = {p_quo[30:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= p_den;
                r_quo[k] <= n_quo[k];
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_quo = r_quo[N-1];
    assign o_side = r_side[N-1];

endmodule

// ===== hdl/bam_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module bam_sqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [31:0]           i_val,
    input  bam_pkg::t_side        i_side,
    output logic                  o_vld,
    output logic [15:0]           o_root,
    output bam_pkg::t_side        o_side
);

    localparam int N = bam_pkg::SQRT_STEPS;

    logic [N-1:0]   r_vld;
    logic [31:0]    r_val [N];
    logic [31:0]    r_root [N];
    bam_pkg::t_side r_side [N];

    logic [31:0]    n_val [N];
    logic [31:0]    n_root [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [31:0] BIT = 32'(1) << (2 * (N - 1 - k));
        logic [31:0]    p_val;
        logic [31:0]    p_root;
        bam_pkg::t_side p_side;
        logic [31:0]    trial;

        if (k == 0) begin : g_first
            assign p_val = i_val;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_val = r_val[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            trial = p_root + BIT;
            if (p_val >= trial) begin
                n_val[k] = p_val - trial;
                n_root[k] = (p_root >> 1) + BIT;
            end else begin
                n_val[k] = p_val;
                n_root[k] = p_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k] <= n_val[k];
                r_root[k] <= n_root[k];
                r_side[k] <= p_side;
            end
        end
    end

    assign o_vld = r_vld[N-1];
    assign o_root = r_root[N-1][15:0];
    assign o_side = r_side[N-1];

endmodule

// ===== hdl/brush_alpha_stamp_falloff.sv =====
// top level: circular brush alpha stamp with quadratic falloff
// pipe order: a, b, c, t2 divider, square root, d, ft divider, e, f, g, h
// throughput: one texel per cycle, set by a fully pipelined datapath with
// one divider bit and one root bit per stage; a stalled output holds the whole pipe
// reset: synchronous active low, clears all valid bits and loads register defaults
`timescale 1ns / 1ps

module brush_alpha_stamp_falloff (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bam_in_if.sink     i_in,
    bam_out_if.source  o_out,
    bam_cfg_if.sink    i_cfg
);

    logic [15:0] r_center_row;
    logic [15:0] r_center_col;
    logic [15:0] r_radius;
    logic [16:0] r_strength;
    logic [16:0] r_falloff;
    logic        r_erase;

    logic en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_row <= '0;
            r_center_col <= '0;
            r_radius <= 16'd256;
            r_strength <= 17'd65536;
            r_falloff <= 17'd32768;
            r_erase <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bam_pkg::REG_CENTER_ROW: r_center_row <= i_cfg.data[15:0];
                bam_pkg::REG_CENTER_COL: r_center_col <= i_cfg.data[15:0];
                bam_pkg::REG_RADIUS:     r_radius <= i_cfg.data[15:0];
                bam_pkg::REG_STRENGTH:   r_strength <= i_cfg.data;
                bam_pkg::REG_FALLOFF:    r_falloff <= i_cfg.data;
                bam_pkg::REG_ERASE:      r_erase <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    logic [16:0] fall_sat;
    logic [16:0] str_sat;
    logic [16:0] inner;
    assign fall_sat = (r_falloff > bam_pkg::ONE_Q16) ? bam_pkg::ONE_Q16 : r_falloff;
    assign str_sat = (r_strength > bam_pkg::ONE_Q16) ? bam_pkg::ONE_Q16 : r_strength;
    assign inner = bam_pkg::ONE_Q16 - fall_sat;

    // stage a: offsets from centre
    logic               r_a_vld;
    logic signed [17:0] r_a_dr;
    logic signed [17:0] r_a_dc;
    logic [7:0]         r_a_alpha;
    logic signed [17:0] n_a_dr;
    logic signed [17:0] n_a_dc;

    // stage b: squares
    logic        r_b_vld;
    logic [31:0] r_b_dr2;
    logic [31:0] r_b_dc2;
    logic [7:0]  r_b_alpha;
    logic signed [35:0] dr_sq;
    logic signed [35:0] dc_sq;

    // stage c: inside test, divider operands
    logic           r_c_vld;
    logic [31:0]    r_c_num;
    logic [31:0]    r_c_den;
    bam_pkg::t_side r_c_side;
    logic [32:0]    d2;
    logic [31:0]    r2;
    logic           hit;

    logic           t2_vld;
    logic [31:0]    t2_quo;
    bam_pkg::t_side t2_side;

    logic           t_vld;
    logic [15:0]    t_root;
    bam_pkg::t_side t_side_s;

    // stage d: falloff operands
    logic           r_d_vld;
    logic [31:0]    r_d_num;
    logic [31:0]    r_d_den;
    bam_pkg::t_side r_d_side;
    logic           flag;

    logic           ft_vld;
    logic [31:0]    ft_quo;
    bam_pkg::t_side ft_side;

    // stage e: ft squared
    logic        r_e_vld;
    logic [15:0] r_e_sq;
    logic        r_e_flag;
    logic [7:0]  r_e_alpha;
    logic        r_e_inside;
    logic [31:0] ft_prod;

    // stage f: strength times influence
    logic        r_f_vld;
    logic [33:0] r_f_m;
    logic [7:0]  r_f_alpha;
    logic        r_f_inside;
    logic [16:0] infl;

    // stage g: times 255
    logic        r_g_vld;
    logic [41:0] r_g_step;
    logic [7:0]  r_g_alpha;
    logic        r_g_inside;

    // stage h: output register
    logic        r_h_vld;
    logic [7:0]  r_h_alpha;
    logic        r_h_inside;
    logic [7:0]  r_h_cur;
    logic [7:0]  n_h_alpha;
    logic [41:0] cur;
    logic [42:0] sum;

    assign en = !r_h_vld || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        n_a_dr = $signed(18'({i_in.texel_row, 8'h80}))
            - 18'(signed'(r_center_row));
        n_a_dc = $signed(18'({i_in.texel_col, 8'h80}))
            - 18'(signed'(r_center_col));
        dr_sq = r_a_dr * r_a_dr;
        dc_sq = r_a_dc * r_a_dc;
        d2 = {1'b0, r_b_dr2} + {1'b0, r_b_dc2};
        r2 = r_radius * r_radius;
        hit = d2 < {1'b0, r2};
        flag = ({1'b0, t_root} > inner) && (fall_sat >= bam_pkg::MIN_FALLOFF);
        ft_prod = ft_quo[31:16] * ft_quo[31:16];
        infl = r_e_flag ? (bam_pkg::ONE_Q16 - {1'b0, r_e_sq}) : bam_pkg::ONE_Q16;
        cur = {2'b00, r_g_alpha, 32'h0};
        sum = {1'b0, cur} + {1'b0, r_g_step};
        if (!r_g_inside) begin
            n_h_alpha = r_g_alpha;
        end else if (r_erase) begin
            n_h_alpha = (r_g_step >= cur) ? 8'h00 : 8'((cur - r_g_step) >> 32);
        end else begin
            n_h_alpha = (sum[42:32] > 11'd255) ? 8'hff : sum[39:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= t_vld;
            r_e_vld <= ft_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dr <= n_a_dr;
            r_a_dc <= n_a_dc;
            r_a_alpha <= i_in.current_alpha;

            r_b_dr2 <= dr_sq[31:0];
            r_b_dc2 <= dc_sq[31:0];
            r_b_alpha <= r_a_alpha;

            r_c_num <= hit ? d2[31:0] : 32'd0;
            r_c_den <= hit ? r2 : 32'd1;
            r_c_side.alpha <= r_b_alpha;
            r_c_side.in_brush <= hit;
            r_c_side.flag <= 1'b0;

            r_d_num <= flag ? 32'({1'b0, t_root} - inner) : 32'd0;
            r_d_den <= flag ? 32'(fall_sat) : 32'd1;
            r_d_side.alpha <= t_side_s.alpha;
            r_d_side.in_brush <= t_side_s.in_brush;
            r_d_side.flag <= flag;

            r_e_sq <= ft_prod[31:16];
            r_e_flag <= ft_side.flag;
            r_e_alpha <= ft_side.alpha;
            r_e_inside <= ft_side.in_brush;

            r_f_m <= str_sat * infl;
            r_f_alpha <= r_e_alpha;
            r_f_inside <= r_e_inside;

            r_g_step <= {r_f_m, 8'h00} - {8'h00, r_f_m};
            r_g_alpha <= r_f_alpha;
            r_g_inside <= r_f_inside;

            r_h_alpha <= n_h_alpha;
            r_h_inside <= r_g_inside;
            r_h_cur <= r_g_alpha;
        end
    end

    bam_div u_div_t2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_vld   (t2_vld),
        .o_quo   (t2_quo),
        .o_side  (t2_side)
    );

    bam_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (t2_vld),
        .i_val   (t2_quo),
        .i_side  (t2_side),
        .o_vld   (t_vld),
        .o_root  (t_root),
        .o_side  (t_side_s)
    );

    bam_div u_div_ft (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d_vld),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .i_side  (r_d_side),
        .o_vld   (ft_vld),
        .o_quo   (ft_quo),
        .o_side  (ft_side)
    );

    assign o_out.valid = r_h_vld;
    assign o_out.new_alpha = r_h_alpha;
    assign o_out.inside_brush = r_h_inside;

`ifndef SYNTHESIS
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow output stall");

    a_outside_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.inside_brush) |-> (o_out.new_alpha == r_h_cur))
        else $error("texel outside brush changed alpha");

    a_paint_raises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.inside_brush && !r_erase) |-> (o_out.new_alpha >= r_h_cur))
        else $error("paint lowered alpha");

    a_erase_lowers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.inside_brush && r_erase) |-> (o_out.new_alpha <= r_h_cur))
        else $error("erase raised alpha");
`endif

endmodule

// ===== verif/tb_top.sv =====
// testbench for the brush alpha stamp: directed and random texel beats checked against a stamp predictor
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] col;
        logic [7:0] alpha;
    } t_texel;

    typedef struct packed {
        logic [7:0] alpha;
        logic       in_brush;
    } t_stamp;

    localparam int LATENCY = 88;
    localparam int STALL_LIMIT = 2000;
    localparam logic [bam_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [bam_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bam_in_if  in_ch();
    bam_out_if out_ch();
    bam_cfg_if cfg_ch();

    brush_alpha_stamp_falloff uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // brush settings as the predictor sees them
    logic signed [15:0] brush_row_q;
    logic signed [15:0] brush_col_q;
    logic [15:0] radius_q;
    logic [16:0] strength_q;
    logic [16:0] falloff_q;
    logic erase_q;

    t_texel texel_q[$];
    t_stamp stamp_q[$];
    int errors = 0;
    bit calm = 1'b0;
    bit stim_done = 1'b0;
    int idle_cycles = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        logic [63:0] rem;
        root = 0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_stamp stamp_texel(input t_texel tx);
        t_stamp res;
        longint signed dr, dc;
        logic [63:0] d2, r2, t2, t, fall, str, inner, infl, ft, sq, step, cur, sum;
        dr = longint'(tx.row) * 256 + 128 - longint'(brush_row_q);
        dc = longint'(tx.col) * 256 + 128 - longint'(brush_col_q);
        d2 = dr * dr + dc * dc;
        r2 = longint'(radius_q) * longint'(radius_q);
        if (d2 >= r2) begin
            res.alpha = tx.alpha;
            res.in_brush = 1'b0;
            return res;
        end
        t2 = (d2 << 32) / r2;
        t = int_sqrt(t2);
        fall = (falloff_q > bam_pkg::ONE_Q16) ? 64'(bam_pkg::ONE_Q16) : 64'(falloff_q);
        str = (strength_q > bam_pkg::ONE_Q16) ? 64'(bam_pkg::ONE_Q16) : 64'(strength_q);
        inner = 64'(bam_pkg::ONE_Q16) - fall;
        infl = 64'(bam_pkg::ONE_Q16);
        if (t > inner && fall >= 64'(bam_pkg::MIN_FALLOFF)) begin
            ft = ((t - inner) << 16) / fall;
            sq = (ft * ft) >> 16;
            infl = (sq >= 64'(bam_pkg::ONE_Q16)) ? 64'd0 : 64'(bam_pkg::ONE_Q16) - sq;
        end
        step = str * infl * 255;
        cur = 64'(tx.alpha) << 32;
        if (erase_q) begin
            res.alpha = (step >= cur) ? 8'd0 : 8'((cur - step) >> 32);
        end else begin
            sum = (cur + step) >> 32;
            res.alpha = (sum > 255) ? 8'd255 : 8'(sum);
        end
        res.in_brush = 1'b1;
        return res;
    endfunction

    // input driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.texel_row <= '0;
            in_ch.texel_col <= '0;
            in_ch.current_alpha <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) stamp_q = {stamp_q, stamp_texel({in_ch.texel_row,
                in_ch.texel_col, in_ch.current_alpha})};
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                in_gap <= $urandom_range(0, 9);
                in_ch.valid <= 1'b0;
            end else if (texel_q.size() > 0) begin
                t_texel tx;
                tx = texel_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.texel_row <= tx.row;
                in_ch.texel_col <= tx.col;
                in_ch.current_alpha <= tx.alpha;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and ready pattern
    int out_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (stamp_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    t_stamp e;
                    e = stamp_q.pop_front();
                    if (out_ch.new_alpha !== e.alpha) begin
                        $error("new_alpha expected %0d actual %0d", e.alpha, out_ch.new_alpha);
                        errors++;
                    end
                    if (out_ch.inside_brush !== e.in_brush) begin
                        $error("inside_brush expected %0d actual %0d", e.in_brush,
                               out_ch.inside_brush);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(0, 9);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [bam_pkg::CFG_IDX_W-1:0] idx,
                             input logic [16:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            bam_pkg::REG_CENTER_ROW: brush_row_q = val[15:0];
            bam_pkg::REG_CENTER_COL: brush_col_q = val[15:0];
            bam_pkg::REG_RADIUS:     radius_q = val[15:0];
            bam_pkg::REG_STRENGTH:   strength_q = val;
            bam_pkg::REG_FALLOFF:    falloff_q = val;
            bam_pkg::REG_ERASE:      erase_q = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (texel_q.size() > 0 || in_ch.valid || stamp_q.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_texel(input logic [5:0] r, input logic [5:0] c, input logic [7:0] a);
        t_texel tx;
        tx = {r, c, a};
        texel_q = {texel_q, tx};
    endtask

    // texels mostly in a box around the brush centre, the rest anywhere on the map
    task automatic random_texels(input int n);
        int cr, cc, span;
        cr = int'(brush_row_q) >>> 8;
        cc = int'(brush_col_q) >>> 8;
        span = int'(radius_q >> 8) + 2;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                push_texel(6'($urandom), 6'($urandom), 8'($urandom));
            else
                push_texel(6'(cr + $urandom_range(0, 2 * span) - span),
                           6'(cc + $urandom_range(0, 2 * span) - span), 8'($urandom));
        end
    endtask

    task automatic random_brush;
        write_reg(bam_pkg::REG_CENTER_ROW, 17'($urandom_range(0, 16383)));
        write_reg(bam_pkg::REG_CENTER_COL, 17'($urandom_range(0, 16383)));
        write_reg(bam_pkg::REG_RADIUS, ($urandom_range(0, 3) == 0)
                  ? 17'($urandom_range(1, 65535)) : 17'($urandom_range(64, 4096)));
        write_reg(bam_pkg::REG_STRENGTH, 17'($urandom_range(0, 131071)));
        write_reg(bam_pkg::REG_FALLOFF, ($urandom_range(0, 4) == 0)
                  ? 17'($urandom_range(0, 70)) : 17'($urandom_range(0, 131071)));
        write_reg(bam_pkg::REG_ERASE, 17'($urandom_range(0, 1)));
    endtask

    initial begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        brush_row_q = 0;
        brush_col_q = 0;
        radius_q = 256;
        strength_q = 65536;
        falloff_q = 32768;
        erase_q = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: brush at the corner, texel 0,0 inside
        push_texel(6'd0, 6'd0, 8'd0);
        push_texel(6'd0, 6'd0, 8'd255);
        push_texel(6'd63, 6'd63, 8'd100);
        push_texel(6'd1, 6'd0, 8'd7);
        drain();

        // large brush in the middle, paint then erase
        write_reg(bam_pkg::REG_CENTER_ROW, 17'h02000);
        write_reg(bam_pkg::REG_CENTER_COL, 17'h02000);
        write_reg(bam_pkg::REG_RADIUS, 17'hFFFF);
        write_reg(bam_pkg::REG_FALLOFF, 17'h1FFFF);
        write_reg(bam_pkg::REG_STRENGTH, 17'h1FFFF);
        push_texel(6'd32, 6'd32, 8'd0);
        push_texel(6'd0, 6'd0, 8'd128);
        push_texel(6'd63, 6'd0, 8'd255);
        push_texel(6'd21, 6'd42, 8'd200);
        drain();
        write_reg(bam_pkg::REG_ERASE, 17'd1);
        write_reg(bam_pkg::REG_FALLOFF, 17'd65);
        write_reg(bam_pkg::REG_STRENGTH, 17'd0);
        push_texel(6'd32, 6'd32, 8'd255);
        drain();
        write_reg(bam_pkg::REG_STRENGTH, 17'd40000);
        write_reg(bam_pkg::REG_FALLOFF, 17'd66);
        push_texel(6'd32, 6'd32, 8'd0);
        push_texel(6'd10, 6'd50, 8'd255);
        push_texel(6'd63, 6'd63, 8'hAA);
        drain();
        // zero radius, centre row at the negative extreme and centre col at the positive extreme
        write_reg(bam_pkg::REG_RADIUS, 17'd0);
        write_reg(bam_pkg::REG_CENTER_ROW, 17'h08000);
        write_reg(bam_pkg::REG_CENTER_COL, 17'h07FFF);
        push_texel(6'd32, 6'd32, 8'd55);
        push_texel(6'd0, 6'd63, 8'd1);
        drain();
        write_reg(bam_pkg::REG_RADIUS, 17'd1);
        write_reg(REG_SPARE_B, 17'h1FFFF);
        write_reg(REG_SPARE_A, 17'd0);
        write_reg(bam_pkg::REG_CENTER_ROW, 17'h00480);
        write_reg(bam_pkg::REG_CENTER_COL, 17'h00480);
        push_texel(6'd4, 6'd4, 8'd90);
        push_texel(6'd4, 6'd5, 8'd90);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            random_brush();
            random_texels(45);
            drain();
        end
        calm = 1'b1;
        random_brush();
        random_texels(45);
        drain();

        stim_done = 1'b1;
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && stamp_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== brush_alpha_stamp_falloff.f =====
hdl/bam_pkg.sv
hdl/bam_if.sv
hdl/bam_div.sv
hdl/bam_sqrt.sv
hdl/brush_alpha_stamp_falloff.sv
verif/tb_top.sv
